// ===== design/socest_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package socest_pkg;

    // Open-circuit-voltage table geometry.
    localparam int TABLE_ROWS  = 21;
    localparam int STORED_COLS = 7;
    localparam int ROW_W       = 5;
    localparam int COL_W       = 3;
    localparam int OCV_W       = 16;

    // Working widths.
    localparam int PCT_W       = 7;
    localparam int MV_W        = 13;
    localparam int TEMP_W      = 8;
    localparam int VTAB_W      = 17;
    localparam int STEP_W      = 14;
    localparam int SUM_W       = 32;
    localparam int IDLE_W      = 16;
    localparam int CYC_W       = 14;
    localparam int DIVIDEND_W  = VTAB_W;
    localparam int DIVISOR_W   = STEP_W;
    localparam int DIV_CNT_W   = $clog2(DIVIDEND_W + 1);

    // Percent constants.
    localparam logic [PCT_W-1:0] FULL_PCT = 7'd100;
    localparam logic [PCT_W-1:0] STEP_PCT = 7'd5;

    // Divide by 5 as multiply by ceil(2^18 / 5), exact for 16-bit values.
    localparam logic [15:0] RECIP5       = 16'd52429;
    localparam int          RECIP5_SHIFT = 18;

    // Divide by 100 as multiply by ceil(2^27 / 100), exact below 2^20.
    localparam int           CYC_IN_W       = 20;
    localparam int           RECIP100_W     = 21;
    localparam logic [20:0]  RECIP100       = 21'd1342178;
    localparam int           RECIP100_SHIFT = 27;
    localparam logic [SUM_W-1:0] CYCLE_LIMIT = 32'd999900;

    localparam logic [IDLE_W-1:0] IDLE_TIMEOUT_RESET = 16'd36000;

    // Opcodes and current directions.
    localparam logic OP_CALIBRATE = 1'b0;
    localparam logic OP_COULOMB   = 1'b1;

    localparam logic [1:0] DIR_NONE      = 2'd0;
    localparam logic [1:0] DIR_CHARGE    = 2'd1;
    localparam logic [1:0] DIR_DISCHARGE = 2'd2;

    // Column temperatures, as temperature codes.
    localparam logic [TEMP_W-1:0] COL_TEMP [STORED_COLS] = '{
        8'd30, 8'd40, 8'd55, 8'd65, 8'd70, 8'd85, 8'd95
    };

    // Rows run from 100 percent down to 0 percent in 5 percent steps.
    localparam logic [OCV_W-1:0] OCV_TABLE [TABLE_ROWS][STORED_COLS] = '{
        '{16'd41796, 16'd41977, 16'd41946, 16'd41799, 16'd41975, 16'd41818, 16'd41965},
        '{16'd41110, 16'd41126, 16'd41139, 16'd41143, 16'd41175, 16'd41130, 16'd41145},
        '{16'd40425, 16'd40434, 16'd40474, 16'd40521, 16'd40488, 16'd40516, 16'd40495},
        '{16'd39870, 16'd39875, 16'd39957, 16'd39986, 16'd39944, 16'd40029, 16'd39945},
        '{16'd39357, 16'd39372, 16'd39438, 16'd39425, 16'd39442, 16'd39515, 16'd39420},
        '{16'd38937, 16'd38910, 16'd38944, 16'd38945, 16'd38949, 16'd38997, 16'd38939},
        '{16'd38442, 16'd38471, 16'd38546, 16'd38576, 16'd38551, 16'd38551, 16'd38558},
        '{16'd37925, 16'd38042, 16'd38088, 16'd37975, 16'd38069, 16'd38105, 16'd38135},
        '{16'd37601, 16'd37597, 16'd37672, 16'd37532, 16'd37717, 16'd37655, 16'd37770},
        '{16'd37198, 16'd37194, 16'd37252, 16'd37429, 16'd37315, 16'd37277, 16'd37365},
        '{16'd36948, 16'd36948, 16'd36995, 16'd36936, 16'd37006, 16'd36990, 16'd37092},
        '{16'd36715, 16'd36753, 16'd36780, 16'd36734, 16'd36814, 16'd36804, 16'd36871},
        '{16'd36538, 16'd36572, 16'd36614, 16'd36563, 16'd36602, 16'd36646, 16'd36693},
        '{16'd36437, 16'd36380, 16'd36423, 16'd36472, 16'd36474, 16'd36506, 16'd36537},
        '{16'd36243, 16'd36252, 16'd36307, 16'd36294, 16'd36324, 16'd36351, 16'd36407},
        '{16'd36006, 16'd36074, 16'd36103, 16'd36101, 16'd36145, 16'd36041, 16'd36188},
        '{16'd35775, 16'd35813, 16'd35846, 16'd35790, 16'd35870, 16'd35796, 16'd35897},
        '{16'd35510, 16'd35690, 16'd35739, 16'd35509, 16'd35807, 16'd35514, 16'd35654},
        '{16'd35349, 16'd35177, 16'd35276, 16'd35105, 16'd35337, 16'd35095, 16'd35346},
        '{16'd34891, 16'd34817, 16'd34848, 16'd34712, 16'd34915, 16'd34711, 16'd34873},
        '{16'd34111, 16'd34595, 16'd34464, 16'd34520, 16'd34549, 16'd34001, 16'd34694}
    };

    // Table lookup request and response.
    typedef struct packed {
        logic              start;
        logic [MV_W-1:0]   voltage_mv;
        logic [TEMP_W-1:0] temp_code;
    } lkp_req_t;

    typedef struct packed {
        logic             done;
        logic [PCT_W-1:0] level;
    } lkp_rsp_t;

    // Divider request and response.
    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

// ===== design/battery_soc_estimator.sv =====
// Battery state-of-charge keeper. A calibrate request converts the cell voltage
// to a charge level by a binary search over the open-circuit-voltage table in
// the chosen temperature column, followed by interpolation between rows; a
// coulomb request moves the level, accumulates discharged percent and counts
// idle steps until the idle timeout puts the block back into calibration wait.
// Requests are handled one at a time. A coulomb request passes the commit,
// multiply and output states. A calibrate request adds a lookup: a probe and
// a compare state per search probe on the table's registered read port (at
// most five probes), one more table read for the neighbor row, and a 17-step
// bit-serial divider for the interpolation. A new request is accepted while
// the previous result is still held on the output. There is no start-up
// clearing pass. The idle_timeout register is written through the cfg port
// and must only be written while no request is in flight.
`timescale 1ns / 1ps
`default_nettype none

module battery_soc_estimator
    import socest_pkg::*;
#(
    parameter int TEMP_COLUMNS = 7
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,

    input  wire logic              item_valid,
    output logic                   item_stall,
    input  wire logic              opcode,
    input  wire logic [MV_W-1:0]   cell_voltage_mv,
    input  wire logic [TEMP_W-1:0] temperature_code,
    input  wire logic [1:0]        direction,
    input  wire logic [PCT_W-1:0]  soc_delta,

    output logic                   result_valid,
    input  wire logic              result_stall,
    output logic [PCT_W-1:0]       charge_level,
    output logic [PCT_W-1:0]       table_level,
    output logic [SUM_W-1:0]       discharge_total,
    output logic [CYC_W-1:0]       cycle_count,
    output logic                   needs_calibration,

    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [IDLE_W-1:0] cfg_data
);

    typedef enum logic [2:0] {
        T_IDLE,
        T_LOOKUP,
        T_COMMIT,
        T_MUL,
        T_OUT
    } top_state_t;

    top_state_t         state_reg;
    logic [IDLE_W-1:0]  timeout_reg;
    logic [PCT_W-1:0]   level_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [IDLE_W-1:0]  idle_reg;
    logic               waiting_reg;
    logic               op_reg;
    logic [1:0]         dir_reg;
    logic [PCT_W-1:0]   delta_reg;
    logic [PCT_W-1:0]   tl_reg;
    logic [CYC_IN_W + RECIP100_W - 1:0] prod_reg;
    logic               below_limit_reg;

    logic               result_valid_reg;
    logic [PCT_W-1:0]   charge_level_reg;
    logic [PCT_W-1:0]   table_level_reg;
    logic [SUM_W-1:0]   discharge_total_reg;
    logic [CYC_W-1:0]   cycle_count_reg;
    logic               needs_calibration_reg;

    logic [PCT_W-1:0]   level_next;
    logic [SUM_W-1:0]   sum_next;
    logic [IDLE_W-1:0]  idle_next;
    logic               waiting_next;
    logic [PCT_W-1:0]   add_amount;
    logic               add_en;
    logic [SUM_W:0]     sum_wide;
    logic [PCT_W:0]     charge_sum;
    logic [IDLE_W-1:0]  idle_inc;

    logic               accept;
    logic               out_free;
    lkp_req_t           lkp_req;
    lkp_rsp_t           lkp_rsp;

    assign item_stall = (state_reg != T_IDLE);
    assign accept     = item_valid && !item_stall;
    assign out_free   = !result_valid_reg || !result_stall;
    assign cfg_ready  = 1'b1;

    // Calibrate requests start the table lookup straight from the ports.
    assign lkp_req.start      = accept && (opcode == OP_CALIBRATE);
    assign lkp_req.voltage_mv = cell_voltage_mv;
    assign lkp_req.temp_code  = temperature_code;

    socest_lookup #(
        .TEMP_COLUMNS (TEMP_COLUMNS)
    ) u_lookup (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (lkp_req),
        .rsp   (lkp_rsp)
    );

    // Saturating add into the discharge total.
    assign sum_wide = {1'b0, sum_reg} + (SUM_W + 1)'(add_amount);

    assign charge_sum = {1'b0, level_reg} + {1'b0, delta_reg};
    assign idle_inc   = idle_reg + 1'b1;

    // Next state of the charge keeper for the request being committed.
    always_comb
    begin
        level_next   = level_reg;
        idle_next    = idle_reg;
        waiting_next = waiting_reg;
        add_amount   = '0;
        add_en       = 1'b0;
        if (op_reg == OP_CALIBRATE)
        begin
            if ((dir_reg == DIR_DISCHARGE) && (tl_reg <= level_reg))
            begin
                add_en     = 1'b1;
                add_amount = level_reg - tl_reg;
            end
            level_next   = tl_reg;
            idle_next    = '0;
            waiting_next = 1'b0;
        end
        else if (!waiting_reg)
        begin
            case (dir_reg)
                DIR_DISCHARGE:
                begin
                    if (level_reg >= delta_reg)
                    begin
                        level_next = level_reg - delta_reg;
                    end
                    add_en     = 1'b1;
                    add_amount = delta_reg;
                    idle_next  = '0;
                end
                DIR_CHARGE:
                begin
                    if (level_reg < FULL_PCT)
                    begin
                        level_next = (charge_sum > {1'b0, FULL_PCT}) ? FULL_PCT
                                                                     : charge_sum[PCT_W-1:0];
                    end
                    else
                    begin
                        level_next = FULL_PCT;
                    end
                    idle_next = '0;
                end
                DIR_NONE:
                begin
                    if (idle_inc >= timeout_reg)
                    begin
                        waiting_next = 1'b1;
                        idle_next    = '0;
                    end
                    else
                    begin
                        idle_next = idle_inc;
                    end
                end
                default:
                begin
                    idle_next = '0;
                end
            endcase
        end
        if (add_en)
        begin
            sum_next = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
        end
        else
        begin
            sum_next = sum_reg;
        end
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= IDLE_TIMEOUT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            timeout_reg <= cfg_data;
        end
    end

    // Request sequencer, keeper state and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg             <= T_IDLE;
            level_reg             <= '0;
            sum_reg               <= '0;
            idle_reg              <= '0;
            waiting_reg           <= 1'b1;
            op_reg                <= OP_CALIBRATE;
            dir_reg               <= DIR_NONE;
            delta_reg             <= '0;
            tl_reg                <= '0;
            prod_reg              <= '0;
            below_limit_reg       <= 1'b0;
            result_valid_reg      <= 1'b0;
            charge_level_reg      <= '0;
            table_level_reg       <= '0;
            discharge_total_reg   <= '0;
            cycle_count_reg       <= '0;
            needs_calibration_reg <= 1'b0;
        end
        else
        begin
            // A taken result is dropped unless a new one replaces it this cycle.
            if (result_valid_reg && !result_stall && !((state_reg == T_OUT) && out_free))
            begin
                result_valid_reg <= 1'b0;
            end
            case (state_reg)
                T_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg    <= opcode;
                        dir_reg   <= direction;
                        delta_reg <= soc_delta;
                        tl_reg    <= '0;
                        state_reg <= (opcode == OP_CALIBRATE) ? T_LOOKUP : T_COMMIT;
                    end
                end
                T_LOOKUP:
                begin
                    if (lkp_rsp.done)
                    begin
                        tl_reg    <= lkp_rsp.level;
                        state_reg <= T_COMMIT;
                    end
                end
                T_COMMIT:
                begin
                    level_reg   <= level_next;
                    sum_reg     <= sum_next;
                    idle_reg    <= idle_next;
                    waiting_reg <= waiting_next;
                    state_reg   <= T_MUL;
                end
                T_MUL:
                begin
                    // Cycle count is the total over 100 by reciprocal multiply.
                    prod_reg <= (CYC_IN_W + RECIP100_W)'(sum_reg[CYC_IN_W-1:0])
                                * (CYC_IN_W + RECIP100_W)'(RECIP100);
                    below_limit_reg <= (sum_reg < CYCLE_LIMIT);
                    state_reg       <= T_OUT;
                end
                T_OUT:
                begin
                    if (out_free)
                    begin
                        result_valid_reg      <= 1'b1;
                        charge_level_reg      <= level_reg;
                        table_level_reg       <= tl_reg;
                        discharge_total_reg   <= sum_reg;
                        cycle_count_reg       <= below_limit_reg
                            ? prod_reg[RECIP100_SHIFT + CYC_W - 1:RECIP100_SHIFT] : '0;
                        needs_calibration_reg <= waiting_reg;
                        state_reg             <= T_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    assign result_valid      = result_valid_reg;
    assign charge_level      = charge_level_reg;
    assign table_level       = table_level_reg;
    assign discharge_total   = discharge_total_reg;
    assign cycle_count       = cycle_count_reg;
    assign needs_calibration = needs_calibration_reg;

`ifndef SYNTH
    // The lookup only answers while a calibrate request waits for it.
    a_lookup_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        lkp_rsp.done |-> (state_reg == T_LOOKUP))
        else $error("lookup response outside lookup wait");

    // The charge level never leaves the percent range.
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= FULL_PCT)
        else $error("charge level above 100");

    // A held result carries a cycle count within its range.
    a_cycle_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (cycle_count_reg <= 14'd9998))
        else $error("cycle count out of range");

    // A committed request always reaches the output stage by way of the multiply stage.
    a_commit_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == T_COMMIT) |-> ##2 (state_reg == T_OUT))
        else $error("commit did not reach output stage");
`endif

endmodule

`default_nettype wire

// ===== design/socest_ocv_rom.sv =====
`timescale 1ns / 1ps
`default_nettype none

module socest_ocv_rom
    import socest_pkg::*;
(
    input  wire logic             clk,
    input  wire logic [ROW_W-1:0] row,
    input  wire logic [COL_W-1:0] col,
    output logic      [OCV_W-1:0] data
);

    logic [OCV_W-1:0] data_reg;

    // Synchronous read port; addresses outside the table read as zero.
    always_ff @(posedge clk)
    begin
        if ((int'(row) < TABLE_ROWS) && (int'(col) < STORED_COLS))
        begin
            data_reg <= OCV_TABLE[row][col];
        end
        else
        begin
            data_reg <= '0;
        end
    end

    assign data = data_reg;

endmodule

`default_nettype wire

// ===== design/socest_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none

module socest_divider
    import socest_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic                  busy_reg;
    logic                  done_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic [DIVIDEND_W-1:0] dq_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  divisor_reg;
    logic [DIVISOR_W:0]    rem_shift;
    logic                  fits;

    // One restoring step: bring down the next dividend bit and try to subtract.
    assign rem_shift = {rem_reg, dq_reg[DIVIDEND_W-1]};
    assign fits      = (rem_shift >= {1'b0, divisor_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            // Done pulses for one cycle after the last step.
            done_reg <= busy_reg && (cnt_reg == DIV_CNT_W'(1));
            if (req.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIVIDEND_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Datapath: the quotient bits shift in where the dividend bits leave.
    always_ff @(posedge clk)
    begin
        if (req.start && !busy_reg)
        begin
            dq_reg      <= req.dividend;
            divisor_reg <= req.divisor;
            rem_reg     <= '0;
        end
        else if (busy_reg)
        begin
            dq_reg <= {dq_reg[DIVIDEND_W-2:0], fits};
            if (fits)
            begin
                rem_reg <= DIVISOR_W'(rem_shift - {1'b0, divisor_reg});
            end
            else
            begin
                rem_reg <= rem_shift[DIVISOR_W-1:0];
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = dq_reg;

endmodule

`default_nettype wire

// ===== design/socest_lookup.sv =====
`timescale 1ns / 1ps
`default_nettype none

module socest_lookup
    import socest_pkg::*;
#(
    parameter int TEMP_COLUMNS = 7
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire lkp_req_t req,
    output lkp_rsp_t      rsp
);

    localparam int NCOL = (TEMP_COLUMNS < STORED_COLS) ? TEMP_COLUMNS : STORED_COLS;

    typedef enum logic [2:0] {
        LK_IDLE,
        LK_PROBE,
        LK_CMP,
        LK_NEIGH,
        LK_GAP,
        LK_STEP,
        LK_DIV
    } lk_state_t;

    lk_state_t            state_reg;
    logic                 done_reg;
    logic [PCT_W-1:0]     result_reg;
    logic [VTAB_W-1:0]    v_reg;
    logic [COL_W-1:0]     col_reg;
    logic signed [5:0]    lo_reg;
    logic signed [5:0]    hi_reg;
    logic [ROW_W-1:0]     mid_reg;
    logic [OCV_W-1:0]     here_reg;
    logic                 up_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [VTAB_W-1:0]    dist_reg;

    logic [VTAB_W-1:0]    v_in;
    logic [COL_W-1:0]     col_pick;
    logic signed [5:0]    span;
    logic signed [5:0]    mid_w;
    logic signed [5:0]    mid_s;
    logic [ROW_W-1:0]     rom_row;
    logic [OCV_W-1:0]     rom_q;
    logic [VTAB_W-1:0]    q_ext;
    logic [VTAB_W-1:0]    here_ext;
    logic                 up;
    logic [PCT_W-1:0]     base_pct;
    logic [OCV_W-1:0]     gap;
    logic [31:0]          step_prod;
    logic [PCT_W-1:0]     interp_pct;
    div_req_t             div_req;
    div_rsp_t             div_rsp;

    // Table voltage is millivolts times ten.
    assign v_in = (VTAB_W'(req.voltage_mv) << 3) + (VTAB_W'(req.voltage_mv) << 1);

    // First column whose temperature is at or above the code, else the last.
    always_comb
    begin
        col_pick = COL_W'(NCOL - 1);
        for (int i = NCOL - 1; i >= 0; i--)
        begin
            if (req.temp_code <= COL_TEMP[i])
            begin
                col_pick = COL_W'(i);
            end
        end
    end

    // Midpoint of the live search window.
    assign span  = hi_reg - lo_reg;
    assign mid_w = lo_reg + (span >>> 1);
    assign mid_s = $signed({1'b0, mid_reg});

    // Probe address during the search, neighbor row afterward.
    assign up = (v_reg > here_ext);

    always_comb
    begin
        if (state_reg == LK_NEIGH)
        begin
            rom_row = up ? (mid_reg - 1'b1) : (mid_reg + 1'b1);
        end
        else
        begin
            rom_row = mid_w[ROW_W-1:0];
        end
    end

    socest_ocv_rom u_rom (
        .clk  (clk),
        .row  (rom_row),
        .col  (col_reg),
        .data (rom_q)
    );

    assign q_ext    = VTAB_W'(rom_q);
    assign here_ext = VTAB_W'(here_reg);
    assign base_pct = FULL_PCT - PCT_W'(PCT_W'(mid_reg) * STEP_PCT);

    // Row gap divided by five through a reciprocal multiply.
    assign gap       = (here_reg > rom_q) ? (here_reg - rom_q) : (rom_q - here_reg);
    assign step_prod = 32'(gap) * 32'(RECIP5);

    // Interpolated percent, clamped to 0..100.
    always_comb
    begin
        if (up_reg)
        begin
            if (div_rsp.quotient > VTAB_W'(FULL_PCT - base_pct))
            begin
                interp_pct = FULL_PCT;
            end
            else
            begin
                interp_pct = base_pct + div_rsp.quotient[PCT_W-1:0];
            end
        end
        else
        begin
            if (div_rsp.quotient >= VTAB_W'(base_pct))
            begin
                interp_pct = '0;
            end
            else
            begin
                interp_pct = base_pct - div_rsp.quotient[PCT_W-1:0];
            end
        end
    end

    assign div_req.start    = (state_reg == LK_STEP) && (step_reg != '0);
    assign div_req.dividend = dist_reg;
    assign div_req.divisor  = step_reg;

    socest_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Search and interpolation sequencer. The done pulse is raised on the
    // way back to idle and dropped in idle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= LK_IDLE;
            done_reg   <= 1'b0;
            result_reg <= '0;
            v_reg      <= '0;
            col_reg    <= '0;
            lo_reg     <= '0;
            hi_reg     <= '0;
            mid_reg    <= '0;
            here_reg   <= '0;
            up_reg     <= 1'b0;
            step_reg   <= '0;
            dist_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                LK_IDLE:
                begin
                    done_reg <= 1'b0;
                    if (req.start)
                    begin
                        v_reg     <= v_in;
                        col_reg   <= col_pick;
                        lo_reg    <= '0;
                        hi_reg    <= 6'(TABLE_ROWS - 1);
                        state_reg <= LK_PROBE;
                    end
                end
                LK_PROBE:
                begin
                    mid_reg   <= mid_w[ROW_W-1:0];
                    state_reg <= LK_CMP;
                end
                LK_CMP:
                begin
                    here_reg <= rom_q;
                    if (v_reg == q_ext)
                    begin
                        result_reg <= base_pct;
                        done_reg   <= 1'b1;
                        state_reg  <= LK_IDLE;
                    end
                    else if (v_reg < q_ext)
                    begin
                        lo_reg    <= mid_s + 6'sd1;
                        state_reg <= ((mid_s + 6'sd1) > hi_reg) ? LK_NEIGH : LK_PROBE;
                    end
                    else
                    begin
                        hi_reg    <= mid_s - 6'sd1;
                        state_reg <= (lo_reg > (mid_s - 6'sd1)) ? LK_NEIGH : LK_PROBE;
                    end
                end
                LK_NEIGH:
                begin
                    up_reg <= up;
                    if (up && (mid_reg == '0))
                    begin
                        result_reg <= FULL_PCT;
                        done_reg   <= 1'b1;
                        state_reg  <= LK_IDLE;
                    end
                    else if (!up && (int'(mid_reg) == TABLE_ROWS - 1))
                    begin
                        result_reg <= '0;
                        done_reg   <= 1'b1;
                        state_reg  <= LK_IDLE;
                    end
                    else
                    begin
                        state_reg <= LK_GAP;
                    end
                end
                LK_GAP:
                begin
                    step_reg  <= step_prod[RECIP5_SHIFT + STEP_W - 1:RECIP5_SHIFT];
                    dist_reg  <= up_reg ? (v_reg - here_ext) : (here_ext - v_reg);
                    state_reg <= LK_STEP;
                end
                LK_STEP:
                begin
                    if (step_reg == '0)
                    begin
                        result_reg <= base_pct;
                        done_reg   <= 1'b1;
                        state_reg  <= LK_IDLE;
                    end
                    else
                    begin
                        state_reg <= LK_DIV;
                    end
                end
                LK_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        result_reg <= interp_pct;
                        done_reg   <= 1'b1;
                        state_reg  <= LK_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= LK_IDLE;
                end
            endcase
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.level = result_reg;

endmodule

`default_nettype wire

// ===== dv/battery_soc_estimator_checker.sv =====
`timescale 1ns / 1ps

// Watches the request, result and register channels of the state-of-charge
// keeper, predicts each result and compares it field by field.
module battery_soc_estimator_checker
    import socest_pkg::*;
#(
    parameter int TEMP_COLUMNS = 7
)
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              item_valid,
    input  logic              item_stall,
    input  logic              opcode,
    input  logic [MV_W-1:0]   cell_voltage_mv,
    input  logic [TEMP_W-1:0] temperature_code,
    input  logic [1:0]        direction,
    input  logic [PCT_W-1:0]  soc_delta,

    input  logic              result_valid,
    input  logic              result_stall,
    input  logic [PCT_W-1:0]  charge_level,
    input  logic [PCT_W-1:0]  table_level,
    input  logic [SUM_W-1:0]  discharge_total,
    input  logic [CYC_W-1:0]  cycle_count,
    input  logic              needs_calibration,

    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [IDLE_W-1:0] cfg_data,

    output int                mismatches,
    output int                outstanding,
    output int                results_checked,
    output int                recal_requests
);

    localparam int USED_COLS = (TEMP_COLUMNS < STORED_COLS) ? TEMP_COLUMNS : STORED_COLS;

    typedef struct packed {
        logic [PCT_W-1:0] level;
        logic [PCT_W-1:0] table_pct;
        logic [SUM_W-1:0] drained;
        logic [CYC_W-1:0] cycles;
        logic             recal;
    } soc_report_t;

    // Predicted block state.
    logic [PCT_W-1:0]  soc_level;
    logic [SUM_W-1:0]  drained_total;
    logic [IDLE_W-1:0] idle_steps;
    logic              recal_pending;
    logic [IDLE_W-1:0] idle_limit;

    soc_report_t pending_reports[$];
    soc_report_t want;

    function automatic logic [SUM_W-1:0] add_saturating(input logic [SUM_W-1:0] a,
                                                        input logic [SUM_W-1:0] b);
        logic [SUM_W:0] total;
        total = {1'b0, a} + {1'b0, b};
        return total[SUM_W] ? '1 : total[SUM_W-1:0];
    endfunction

    // Voltage to percent: column pick, binary search over the rows, then
    // linear interpolation toward the neighbor row with clamping.
    function automatic logic [PCT_W-1:0] ocv_to_percent(input logic [MV_W-1:0]   mv,
                                                       input logic [TEMP_W-1:0] tc);
        int          col;
        int          i;
        int          lo;
        int          hi;
        int          mid;
        int          pct;
        int unsigned volts;
        int unsigned here;
        int unsigned other;
        int unsigned row_gap;
        int unsigned row_step;
        int unsigned offset_v;
        col = USED_COLS - 1;
        for (i = USED_COLS - 1; i >= 0; i--)
        begin
            if (tc <= COL_TEMP[i])
                col = i;
        end
        volts = int'(mv) * 10;
        lo = 0;
        hi = TABLE_ROWS - 1;
        mid = 0;
        while (lo <= hi)
        begin
            mid = lo + (hi - lo) / 2;
            here = OCV_TABLE[mid][col];
            if (volts == here)
                return PCT_W'(100 - mid * 5);
            if (volts < here)
                lo = mid + 1;
            else
                hi = mid - 1;
        end
        pct = 100 - mid * 5;
        here = OCV_TABLE[mid][col];
        if (volts > here)
        begin
            if (mid == 0)
                return FULL_PCT;
            other = OCV_TABLE[mid - 1][col];
            row_gap = (here > other) ? here - other : other - here;
            row_step = row_gap / 5;
            offset_v = volts - here;
            if (row_step != 0)
                pct = pct + int'(offset_v / row_step);
        end
        else
        begin
            if (mid >= TABLE_ROWS - 1)
                return '0;
            other = OCV_TABLE[mid + 1][col];
            row_gap = (here > other) ? here - other : other - here;
            row_step = row_gap / 5;
            offset_v = here - volts;
            if (row_step != 0)
                pct = pct - int'(offset_v / row_step);
        end
        if (pct < 0)
            pct = 0;
        if (pct > 100)
            pct = 100;
        return PCT_W'(pct);
    endfunction

    // Applies one request to the predicted state and returns its result.
    function automatic soc_report_t apply_request(input logic              op,
                                                  input logic [MV_W-1:0]   mv,
                                                  input logic [TEMP_W-1:0] tc,
                                                  input logic [1:0]        dir,
                                                  input logic [PCT_W-1:0]  delta);
        soc_report_t      rep;
        logic [PCT_W-1:0] tl;
        logic [PCT_W:0]   raised;
        tl = '0;
        if (op == OP_CALIBRATE)
        begin
            tl = ocv_to_percent(mv, tc);
            if (dir == DIR_DISCHARGE && tl <= soc_level)
                drained_total = add_saturating(drained_total, SUM_W'(soc_level - tl));
            soc_level = tl;
            idle_steps = '0;
            recal_pending = 1'b0;
        end
        else if (!recal_pending)
        begin
            if (dir == DIR_DISCHARGE)
            begin
                // A drop larger than the level leaves the level alone.
                if (soc_level >= delta)
                    soc_level = soc_level - delta;
                drained_total = add_saturating(drained_total, SUM_W'(delta));
            end
            else if (dir == DIR_CHARGE)
            begin
                raised = soc_level + delta;
                soc_level = (raised > FULL_PCT) ? FULL_PCT : raised[PCT_W-1:0];
            end
            if (dir == DIR_NONE)
            begin
                idle_steps = idle_steps + 1'b1;
                if (idle_steps >= idle_limit)
                begin
                    recal_pending = 1'b1;
                    idle_steps = '0;
                    recal_requests++;
                end
            end
            else
            begin
                idle_steps = '0;
            end
        end
        rep.level = soc_level;
        rep.table_pct = tl;
        rep.drained = drained_total;
        rep.cycles = (drained_total < CYCLE_LIMIT) ? CYC_W'(drained_total / 100) : '0;
        rep.recal = recal_pending;
        return rep;
    endfunction

    function automatic int field_differs(input string name,
                                         input longint unsigned want_v,
                                         input longint unsigned got_v);
        if (want_v != got_v)
        begin
            $error("%s: expected %0d, actual %0d", name, want_v, got_v);
            return 1;
        end
        return 0;
    endfunction

    // Register writes, accepted requests and accepted results, in edge order.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            soc_level = '0;
            drained_total = '0;
            idle_steps = '0;
            recal_pending = 1'b1;
            idle_limit = IDLE_TIMEOUT_RESET;
            pending_reports.delete();
            mismatches = 0;
            outstanding = 0;
            results_checked = 0;
            recal_requests = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                idle_limit = cfg_data;
            if (item_valid && !item_stall)
                pending_reports.push_back(apply_request(opcode, cell_voltage_mv,
                                                        temperature_code, direction,
                                                        soc_delta));
            if (result_valid && !result_stall)
            begin
                if (pending_reports.size() == 0)
                begin
                    $error("result with no request waiting: charge_level %0d", charge_level);
                    mismatches++;
                end
                else
                begin
                    want = pending_reports.pop_front();
                    mismatches += field_differs("charge_level", want.level, charge_level);
                    mismatches += field_differs("table_level", want.table_pct, table_level);
                    mismatches += field_differs("discharge_total", want.drained,
                                                discharge_total);
                    mismatches += field_differs("cycle_count", want.cycles, cycle_count);
                    mismatches += field_differs("needs_calibration", want.recal,
                                                needs_calibration);
                    results_checked++;
                end
            end
            outstanding = pending_reports.size();
        end
    end

endmodule

// ===== dv/battery_soc_estimator_tb.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the state-of-charge keeper; the checker beside
// the block does all prediction and comparison.
module battery_soc_estimator_tb
    import socest_pkg::*;
;

    localparam int TEMP_COLUMNS = 7;
    localparam int RUN_LIMIT    = 3000000;
    localparam int LONG_HOLD    = 300;

    // Current direction that holds the level and clears the idle count.
    localparam logic [1:0] DIR_HOLD = 2'd3;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;

    logic              item_valid = 1'b0;
    logic              item_stall;
    logic              opcode = OP_CALIBRATE;
    logic [MV_W-1:0]   cell_voltage_mv = '0;
    logic [TEMP_W-1:0] temperature_code = '0;
    logic [1:0]        direction = DIR_NONE;
    logic [PCT_W-1:0]  soc_delta = '0;

    logic              result_valid;
    logic              result_stall = 1'b0;
    logic [PCT_W-1:0]  charge_level;
    logic [PCT_W-1:0]  table_level;
    logic [SUM_W-1:0]  discharge_total;
    logic [CYC_W-1:0]  cycle_count;
    logic              needs_calibration;

    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [IDLE_W-1:0] cfg_data = '0;

    int mismatches;
    int outstanding;
    int results_checked;
    int recal_requests;

    int elapsed_cycles = 0;
    int calibrate_sent = 0;
    int coulomb_sent = 0;
    int burst_left = 0;
    int gap_max = 8;
    int hold_ticket = 0;

    // Receiver state.
    int          seen_ticket;
    int          hold_left;
    int          segment_left;
    stall_mode_t stall_mode;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    battery_soc_estimator #(.TEMP_COLUMNS(TEMP_COLUMNS)) dut (.*);

    battery_soc_estimator_checker #(.TEMP_COLUMNS(TEMP_COLUMNS)) soc_checker (.*);

    // Run-length guard.
    always @(posedge clk)
    begin
        elapsed_cycles++;
        if (elapsed_cycles > RUN_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Result-side stall pattern, with a long hold-off whenever the ticket moves.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            seen_ticket = 0;
            hold_left = 0;
            segment_left = 0;
            stall_mode = STALL_NONE;
        end
        else
        begin
            if (hold_ticket != seen_ticket)
            begin
                seen_ticket = hold_ticket;
                hold_left = LONG_HOLD;
            end
            if (segment_left == 0)
            begin
                stall_mode = stall_mode_t'($urandom_range(0, 3));
                segment_left = $urandom_range(8, 64);
            end
            else
            begin
                segment_left--;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
            begin
                case (stall_mode)
                    STALL_NONE:   result_stall <= 1'b0;
                    STALL_LIGHT:  result_stall <= ($urandom_range(0, 7) == 0);
                    STALL_HEAVY:  result_stall <= $urandom_range(0, 1);
                    default:      result_stall <= !result_stall;
                endcase
            end
        end
    end

    // Offers one request in the sender's burst pattern and returns at the
    // edge where it is accepted.
    task automatic send_request(input logic              op,
                                input logic [MV_W-1:0]   mv,
                                input logic [TEMP_W-1:0] tc,
                                input logic [1:0]        dir,
                                input logic [PCT_W-1:0]  delta);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = (gap_max == 0 || $urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, gap_max);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        item_valid <= 1'b1;
        opcode <= op;
        cell_voltage_mv <= mv;
        temperature_code <= tc;
        direction <= dir;
        soc_delta <= delta;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        if (op == OP_CALIBRATE)
            calibrate_sent++;
        else
            coulomb_sent++;
    endtask

    // Stops offering and waits until every predicted result has been seen.
    task automatic wait_until_drained();
        item_valid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
        @(posedge clk);
    endtask

    task automatic write_idle_timeout(input logic [IDLE_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly plausible measurements: voltages inside the table span, exact
    // table voltages, column-edge temperatures, with some full-range noise.
    task automatic offer_random_request();
        logic              op;
        logic [MV_W-1:0]   mv;
        logic [TEMP_W-1:0] tc;
        logic [1:0]        dir;
        logic [PCT_W-1:0]  delta;
        int                pick;
        int                row;
        int                col;
        op = ($urandom_range(0, 99) < 28) ? OP_CALIBRATE : OP_COULOMB;
        row = $urandom_range(0, TABLE_ROWS - 1);
        col = $urandom_range(0, STORED_COLS - 1);
        pick = $urandom_range(0, 99);
        if (pick < 15)
        begin
            mv = MV_W'(OCV_TABLE[row][col] / 10);
            tc = COL_TEMP[col];
        end
        else
        begin
            if (pick < 80)
                mv = MV_W'($urandom_range(3380, 4220));
            else
                mv = MV_W'($urandom);
            if ($urandom_range(0, 99) < 30)
                tc = COL_TEMP[col] + TEMP_W'($urandom_range(0, 1));
            else
                tc = TEMP_W'($urandom);
        end
        pick = $urandom_range(0, 99);
        if (pick < 35)
            dir = DIR_NONE;
        else if (pick < 60)
            dir = DIR_CHARGE;
        else if (pick < 92)
            dir = DIR_DISCHARGE;
        else
            dir = DIR_HOLD;
        if ($urandom_range(0, 99) < 80)
            delta = PCT_W'($urandom_range(0, 30));
        else
            delta = PCT_W'($urandom);
        send_request(op, mv, tc, dir, delta);
    endtask

    // One timeout setting; the sender drains halfway through and the receiver
    // may be asked for a long hold-off while requests keep coming.
    task automatic run_random_phase(input logic [IDLE_W-1:0] timeout_value,
                                    input int count,
                                    input bit with_hold);
        int k;
        wait_until_drained();
        write_idle_timeout(timeout_value);
        for (k = 0; k < count; k++)
        begin
            if (with_hold && k == 40)
                hold_ticket <= hold_ticket + 1;
            if (k == count / 2)
                wait_until_drained();
            offer_random_request();
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests under the reset timeout.
        // Coulomb step before any calibration is ignored.
        send_request(OP_COULOMB, 13'd6553, 8'd255, DIR_DISCHARGE, 7'd50);
        // Exact table hits, above the top row and below the bottom row.
        send_request(OP_CALIBRATE, 13'd4111, 8'd0, DIR_DISCHARGE, 7'd0);
        send_request(OP_CALIBRATE, 13'h1FFF, 8'd255, DIR_CHARGE, 7'h7F);
        send_request(OP_CALIBRATE, 13'd0, 8'd30, DIR_DISCHARGE, 7'd0);
        send_request(OP_CALIBRATE, 13'd3891, 8'd31, DIR_HOLD, 7'd0);
        send_request(OP_CALIBRATE, 13'd3987, 8'd30, DIR_NONE, 7'd0);
        // Interpolation in columns 2 to 6, across the column edges.
        send_request(OP_CALIBRATE, 13'd3800, 8'd41, DIR_DISCHARGE, 7'd5);
        send_request(OP_CALIBRATE, 13'd3700, 8'd56, DIR_CHARGE, 7'd0);
        send_request(OP_CALIBRATE, 13'd3650, 8'd66, DIR_DISCHARGE, 7'd0);
        send_request(OP_CALIBRATE, 13'd3600, 8'd71, DIR_NONE, 7'd0);
        send_request(OP_CALIBRATE, 13'd3550, 8'd86, DIR_DISCHARGE, 7'd0);
        send_request(OP_CALIBRATE, 13'd3900, 8'd96, DIR_NONE, 7'd0);
        send_request(OP_CALIBRATE, 13'd4000, 8'd55, DIR_NONE, 7'd0);
        send_request(OP_CALIBRATE, 13'd3750, 8'd65, DIR_NONE, 7'd0);
        send_request(OP_CALIBRATE, 13'd3450, 8'd70, DIR_NONE, 7'd0);
        send_request(OP_CALIBRATE, 13'd3451, 8'd85, DIR_NONE, 7'd0);
        send_request(OP_CALIBRATE, 13'd3500, 8'd95, DIR_DISCHARGE, 7'd0);
        // Charge to the cap, drops larger than the level, hold and idle.
        send_request(OP_COULOMB, 13'h0AAA, 8'h55, DIR_CHARGE, 7'h7F);
        send_request(OP_COULOMB, 13'h1555, 8'hAA, DIR_CHARGE, 7'd10);
        send_request(OP_COULOMB, 13'd0, 8'd0, DIR_DISCHARGE, 7'h7F);
        send_request(OP_COULOMB, 13'd0, 8'd0, DIR_DISCHARGE, 7'd100);
        send_request(OP_COULOMB, 13'd0, 8'd0, DIR_DISCHARGE, 7'd1);
        send_request(OP_COULOMB, 13'd0, 8'd0, DIR_HOLD, 7'd64);
        send_request(OP_COULOMB, 13'd0, 8'd0, DIR_NONE, 7'd0);
        send_request(OP_COULOMB, 13'd0, 8'd0, DIR_CHARGE, 7'd64);

        // Random requests over a spread of timeout settings.
        run_random_phase(16'd3, 200, 1'b0);
        run_random_phase(16'd0, 200, 1'b1);
        run_random_phase(16'd1, 200, 1'b0);
        run_random_phase(16'd12, 200, 1'b0);
        run_random_phase(IDLE_TIMEOUT_RESET, 200, 1'b1);
        run_random_phase(16'd2, 200, 1'b0);
        run_random_phase(16'd40, 200, 1'b0);
        run_random_phase(16'd7, 200, 1'b0);
        run_random_phase(16'd5, 100, 1'b0);

        wait_until_drained();
        repeat (40) @(posedge clk);

        $display("Checked %0d results: %0d calibrate and %0d coulomb requests, %0d idle timeouts.",
                 results_checked, calibrate_sent, coulomb_sent, recal_requests);
        $display("Timeouts from 0 to 36000 were used, with long result hold-offs and drained pauses.");
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
